/* src/pctd_pkg.sv */
// Shared types, constants and fixed-point helpers for the column tridiagonal solver.
package pctd_pkg;

    localparam int LEVELS_DEF = 64;
    localparam int VW = 48;
    localparam int WW = 51;
    localparam int MW = 144;

    localparam logic [1:0] CFG_INV_DZ_SQ = 2'd0;
    localparam logic [1:0] CFG_RECIP_DT  = 2'd1;

    localparam logic [31:0]          Q_ONE   = 32'h0001_0000;
    localparam logic signed [VW-1:0] SAT_HI  = 48'sh7FFF_FFFF_FFFF;
    localparam logic [VW-1:0]        MAG_CAP = 48'h8000_0000_0000;
    localparam logic signed [WW-1:0] SAT_HI_W = 51'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [WW-1:0] SAT_LO_W = 51'sh7_8000_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_DRE,
        ST_MUL_DIM,
        ST_MUL_DEN,
        ST_MUL_RRE,
        ST_MUL_RIM,
        ST_DIV_START,
        ST_DIV,
        ST_EMIT,
        ST_BACK_RD,
        ST_MUL_SRE,
        ST_MUL_SIM
    } ctrl_state_t;

    typedef enum logic [2:0] {
        OP_DRE,
        OP_DIM,
        OP_DEN,
        OP_RRE,
        OP_RIM,
        OP_SRE,
        OP_SIM
    } mul_op_t;

    typedef struct packed {
        logic    in_take;
        logic    mul_start;
        mul_op_t mul_op;
        logic    den_first;
        logic    div_start;
        logic    row_commit;
        logic    out_load;
        logic    back_read;
        logic    end_column;
    } pctd_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic first;
        logic last;
        logic idx_zero;
        logic out_free;
    } pctd_stat_t;

    function automatic logic [VW-1:0] mag48(input logic signed [VW-1:0] v);
        logic [VW-1:0] m;
        m = v[VW-1] ? (~v + 1'b1) : v;
        return m;
    endfunction

    function automatic logic signed [VW-1:0] sign_cap(input logic [VW-1:0] mag,
                                                      input logic neg);
        logic signed [VW-1:0] r;
        if (neg)
            r = ~mag + 1'b1;
        else if (mag[VW-1])
            r = SAT_HI;
        else
            r = mag;
        return r;
    endfunction

    function automatic logic signed [VW-1:0] sat48(input logic signed [WW-1:0] v);
        logic signed [VW-1:0] r;
        if (v > SAT_HI_W)
            r = SAT_HI;
        else if (v < SAT_LO_W)
            r = ~SAT_HI;
        else
            r = v[VW-1:0];
        return r;
    endfunction

    function automatic logic signed [31:0] out32(input logic signed [VW-1:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < 48'shFFFF_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* src/pctd_mul.sv */
// Sequential Q32.16 magnitude multiplier built on one 24x24 partial product per cycle.
module pctd_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [pctd_pkg::VW-1:0] x,
    input  logic signed [pctd_pkg::VW-1:0] y,
    output logic                         done,
    output logic signed [pctd_pkg::VW-1:0] res
);
    import pctd_pkg::*;

    logic [VW-1:0]        mx_reg;
    logic [VW-1:0]        my_reg;
    logic                 neg_reg;
    logic [95:0]          acc_reg;
    logic [95:0]          acc_next;
    logic [1:0]           step_reg;
    logic                 busy_reg;
    logic                 fin_reg;
    logic                 done_reg;
    logic signed [VW-1:0] res_reg;
    logic signed [VW-1:0] res_next;
    logic [23:0]          pa;
    logic [23:0]          pb;
    logic [47:0]          pp;
    logic [95:0]          pp_sh;
    logic [VW-1:0]        mag;

    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                pa = mx_reg[23:0];
                pb = my_reg[23:0];
            end
            2'd1:
            begin
                pa = mx_reg[23:0];
                pb = my_reg[47:24];
            end
            2'd2:
            begin
                pa = mx_reg[47:24];
                pb = my_reg[23:0];
            end
            default:
            begin
                pa = mx_reg[47:24];
                pb = my_reg[47:24];
            end
        endcase
        pp = pa * pb;
        case (step_reg)
            2'd0:    pp_sh = {48'd0, pp};
            2'd1:    pp_sh = {24'd0, pp, 24'd0};
            2'd2:    pp_sh = {24'd0, pp, 24'd0};
            default: pp_sh = {pp, 48'd0};
        endcase
        acc_next = acc_reg + pp_sh;
        if ((|acc_reg[95:64]) || (acc_reg[63:16] > MAG_CAP))
            mag = MAG_CAP;
        else
            mag = acc_reg[63:16];
        res_next = sign_cap(mag, neg_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mx_reg  <= mag48(x);
            my_reg  <= mag48(y);
            neg_reg <= x[VW-1] ^ y[VW-1];
            acc_reg <= 96'd0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
        if (fin_reg)
            res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

    a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (!busy_reg && !fin_reg))
        else $error("multiplier started while busy");

endmodule

/* src/pctd_div.sv */
// Three-lane restoring divider sharing one divisor, one quotient bit per cycle.
module pctd_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic signed [pctd_pkg::VW-1:0] num [3],
    input  logic signed [pctd_pkg::VW-1:0] den,
    output logic                           done,
    output logic signed [pctd_pkg::VW-1:0] res [3]
);
    import pctd_pkg::*;

    logic [VW-1:0]        md_reg;
    logic [VW-1:0]        rem_reg  [3];
    logic [VW-1:0]        rem_next [3];
    logic [63:0]          quo_reg  [3];
    logic [63:0]          quo_next [3];
    logic                 neg_reg  [3];
    logic signed [VW-1:0] res_reg  [3];
    logic signed [VW-1:0] res_next [3];
    logic [VW:0]          trial    [3];
    logic [VW:0]          diff     [3];
    logic [VW-1:0]        qcap     [3];
    logic                 ge       [3];
    logic [5:0]           cnt_reg;
    logic                 busy_reg;
    logic                 fin_reg;
    logic                 done_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            trial[l] = {rem_reg[l], quo_reg[l][63]};
            diff[l]  = trial[l] - {1'b0, md_reg};
            ge[l]    = (trial[l] >= {1'b0, md_reg});
            rem_next[l] = ge[l] ? diff[l][VW-1:0] : trial[l][VW-1:0];
            quo_next[l] = {quo_reg[l][62:0], ge[l]};
            if ((|quo_reg[l][63:48]) || (quo_reg[l][47:0] > MAG_CAP))
                qcap[l] = MAG_CAP;
            else
                qcap[l] = quo_reg[l][47:0];
            res_next[l] = sign_cap(qcap[l], neg_reg[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            md_reg <= mag48(den);
        for (int l = 0; l < 3; l++)
        begin
            if (start)
            begin
                rem_reg[l] <= '0;
                quo_reg[l] <= {mag48(num[l]), 16'd0};
                neg_reg[l] <= num[l][VW-1] ^ den[VW-1];
            end
            else if (busy_reg)
            begin
                rem_reg[l] <= rem_next[l];
                quo_reg[l] <= quo_next[l];
            end
            if (fin_reg)
                res_reg[l] <= res_next[l];
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (!busy_reg && !fin_reg))
        else $error("divider started while busy");

endmodule

/* src/pctd_ctrl.sv */
// Sequencer for the forward sweep, back substitution and result hand-off.
module pctd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  pctd_pkg::pctd_stat_t   stat,
    output pctd_pkg::pctd_cmd_t    cmd
);
    import pctd_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = OP_DRE;
        in_stall   = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_take   = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = OP_DRE;
                    state_next    = ST_MUL_DRE;
                end
            end
            ST_MUL_DRE:
            begin
                if (stat.mul_done)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = OP_DIM;
                    state_next    = ST_MUL_DIM;
                end
            end
            ST_MUL_DIM:
            begin
                if (stat.mul_done)
                begin
                    if (stat.first)
                    begin
                        cmd.den_first = 1'b1;
                        state_next    = ST_DIV_START;
                    end
                    else
                    begin
                        cmd.mul_start = 1'b1;
                        cmd.mul_op    = OP_DEN;
                        state_next    = ST_MUL_DEN;
                    end
                end
            end
            ST_MUL_DEN:
            begin
                if (stat.mul_done)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = OP_RRE;
                    state_next    = ST_MUL_RRE;
                end
            end
            ST_MUL_RRE:
            begin
                if (stat.mul_done)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = OP_RIM;
                    state_next    = ST_MUL_RIM;
                end
            end
            ST_MUL_RIM:
            begin
                if (stat.mul_done)
                    state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.row_commit = 1'b1;
                    state_next     = stat.last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.idx_zero)
                    begin
                        cmd.end_column = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        cmd.back_read = 1'b1;
                        state_next    = ST_BACK_RD;
                    end
                end
            end
            ST_BACK_RD:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = OP_SRE;
                state_next    = ST_MUL_SRE;
            end
            ST_MUL_SRE:
            begin
                if (stat.mul_done)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = OP_SIM;
                    state_next    = ST_MUL_SIM;
                end
            end
            ST_MUL_SIM:
            begin
                if (stat.mul_done)
                    state_next = ST_EMIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/pctd_datapath.sv */
// Row builder, sweep store, shared arithmetic units and output register.
module pctd_datapath #(
    parameter int LEVELS = pctd_pkg::LEVELS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pctd_pkg::pctd_cmd_t  cmd,
    output pctd_pkg::pctd_stat_t stat,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic [31:0]          kh_sq,
    input  logic signed [31:0]   div_re,
    input  logic signed [31:0]   div_im,
    input  logic                 last_row,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   press_re,
    output logic signed [31:0]   press_im,
    output logic                 singular,
    output logic                 last_out
);
    import pctd_pkg::*;

    localparam int RW = $clog2(LEVELS);
    localparam logic [RW-1:0] ROW_MAX = RW'(LEVELS - 1);

    logic [31:0]          inv_dz_sq_reg;
    logic [31:0]          recip_dt_reg;
    logic [31:0]          column_kh_reg;
    logic [RW-1:0]        row_count_reg;
    logic                 pivot_reg;
    logic signed [VW-1:0] sol_re_reg;
    logic signed [VW-1:0] sol_im_reg;
    logic [RW-1:0]        idx_reg;

    logic signed [31:0]   div_re_reg;
    logic signed [31:0]   div_im_reg;
    logic                 first_reg;
    logic                 last_reg;
    logic                 kz_reg;
    logic signed [WW-1:0] b_reg;
    logic signed [VW-1:0] c_reg;
    logic signed [VW-1:0] d_re_reg;
    logic signed [VW-1:0] d_im_reg;
    logic signed [VW-1:0] den_reg;
    mul_op_t              mul_op_reg;

    logic [MW-1:0]        mem [LEVELS];
    logic [MW-1:0]        rd_reg;
    logic                 mem_re;
    logic [RW-1:0]        mem_raddr;

    logic                 out_valid_reg;
    logic signed [31:0]   press_re_reg;
    logic signed [31:0]   press_im_reg;
    logic                 singular_reg;
    logic                 last_out_reg;

    logic                 first_now;
    logic                 last_now;
    logic [31:0]          k_now;
    logic                 kz_now;
    logic signed [WW-1:0] s_w;
    logic signed [WW-1:0] k_w;
    logic signed [WW-1:0] b_next;
    logic signed [VW-1:0] c_next;

    logic signed [VW-1:0] rd_ur;
    logic signed [VW-1:0] rd_re;
    logic signed [VW-1:0] rd_im;

    logic                 mul_go_reg;
    mul_op_t              mul_go_op_reg;
    logic signed [VW-1:0] mul_x;
    logic signed [VW-1:0] mul_y;
    logic                 mul_done;
    logic signed [VW-1:0] mul_res;
    logic signed [WW-1:0] mul_res_w;

    logic signed [VW-1:0] div_num [3];
    logic                 div_done;
    logic signed [VW-1:0] div_res [3];

    logic                 den_zero;
    logic signed [VW-1:0] cp_val;
    logic signed [VW-1:0] dp_re_val;
    logic signed [VW-1:0] dp_im_val;

    assign rd_ur = rd_reg[143:96];
    assign rd_re = rd_reg[95:48];
    assign rd_im = rd_reg[47:0];

    always_comb
    begin
        first_now = (row_count_reg == '0);
        last_now  = last_row || (row_count_reg == ROW_MAX);
        k_now     = first_now ? kh_sq : column_kh_reg;
        kz_now    = (k_now == 32'd0);
        s_w       = {{(WW-32){1'b0}}, inv_dz_sq_reg};
        k_w       = {{(WW-32){1'b0}}, k_now};
        if (last_now)
        begin
            b_next = -s_w - k_w;
            c_next = '0;
        end
        else if (first_now)
        begin
            if (kz_now)
            begin
                b_next = {{(WW-32){1'b0}}, Q_ONE};
                c_next = '0;
            end
            else
            begin
                b_next = -s_w - k_w;
                c_next = {{(VW-32){1'b0}}, inv_dz_sq_reg};
            end
        end
        else
        begin
            b_next = -(s_w <<< 1) - k_w;
            c_next = {{(VW-32){1'b0}}, inv_dz_sq_reg};
        end
    end

    // Register the start so the operand mux already sees the loaded input registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_go_reg <= 1'b0;
        else
            mul_go_reg <= cmd.mul_start;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
            mul_go_op_reg <= cmd.mul_op;
    end

    always_comb
    begin
        case (mul_go_op_reg)
            OP_DRE:
            begin
                mul_x = {{(VW-32){div_re_reg[31]}}, div_re_reg};
                mul_y = {{(VW-32){1'b0}}, recip_dt_reg};
            end
            OP_DIM:
            begin
                mul_x = {{(VW-32){div_im_reg[31]}}, div_im_reg};
                mul_y = {{(VW-32){1'b0}}, recip_dt_reg};
            end
            OP_DEN:
            begin
                mul_x = {{(VW-32){1'b0}}, inv_dz_sq_reg};
                mul_y = rd_ur;
            end
            OP_RRE:
            begin
                mul_x = {{(VW-32){1'b0}}, inv_dz_sq_reg};
                mul_y = rd_re;
            end
            OP_RIM:
            begin
                mul_x = {{(VW-32){1'b0}}, inv_dz_sq_reg};
                mul_y = rd_im;
            end
            OP_SRE:
            begin
                mul_x = rd_ur;
                mul_y = sol_re_reg;
            end
            OP_SIM:
            begin
                mul_x = rd_ur;
                mul_y = sol_im_reg;
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    pctd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_go_reg),
        .x     (mul_x),
        .y     (mul_y),
        .done  (mul_done),
        .res   (mul_res)
    );

    assign mul_res_w = {{(WW-VW){mul_res[VW-1]}}, mul_res};

    assign div_num[0] = c_reg;
    assign div_num[1] = d_re_reg;
    assign div_num[2] = d_im_reg;

    pctd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (den_reg),
        .done  (div_done),
        .res   (div_res)
    );

    always_comb
    begin
        den_zero  = (den_reg == '0);
        cp_val    = den_zero ? '0 : div_res[0];
        dp_re_val = den_zero ? '0 : div_res[1];
        dp_im_val = den_zero ? '0 : div_res[2];
        mem_re    = cmd.in_take || cmd.back_read;
        mem_raddr = cmd.in_take ? (row_count_reg - 1'b1) : (idx_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_dz_sq_reg <= Q_ONE;
            recip_dt_reg  <= Q_ONE;
            column_kh_reg <= '0;
            row_count_reg <= '0;
            pivot_reg     <= 1'b0;
            sol_re_reg    <= '0;
            sol_im_reg    <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_INV_DZ_SQ: inv_dz_sq_reg <= cfg_data;
                    CFG_RECIP_DT:  recip_dt_reg  <= cfg_data;
                    default:       ;
                endcase
            end
            if (cmd.in_take && first_now)
                column_kh_reg <= kh_sq;
            if (cmd.row_commit)
            begin
                if (den_zero)
                    pivot_reg <= 1'b1;
                if (last_reg)
                begin
                    idx_reg    <= row_count_reg;
                    sol_re_reg <= dp_re_val;
                    sol_im_reg <= dp_im_val;
                end
                else
                begin
                    row_count_reg <= row_count_reg + 1'b1;
                end
            end
            if (cmd.back_read)
                idx_reg <= idx_reg - 1'b1;
            if (mul_done && (mul_op_reg == OP_SRE))
                sol_re_reg <= sat48({{(WW-VW){rd_re[VW-1]}}, rd_re} - mul_res_w);
            if (mul_done && (mul_op_reg == OP_SIM))
                sol_im_reg <= sat48({{(WW-VW){rd_im[VW-1]}}, rd_im} - mul_res_w);
            if (cmd.end_column)
            begin
                row_count_reg <= '0;
                pivot_reg     <= 1'b0;
                column_kh_reg <= '0;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_take)
        begin
            div_re_reg <= div_re;
            div_im_reg <= div_im;
            first_reg  <= first_now;
            last_reg   <= last_now;
            kz_reg     <= kz_now;
            b_reg      <= b_next;
            c_reg      <= c_next;
        end
        if (mul_go_reg)
            mul_op_reg <= mul_go_op_reg;
        if (mul_done)
        begin
            case (mul_op_reg)
                OP_DRE: d_re_reg <= (first_reg && kz_reg) ? '0 : mul_res;
                OP_DIM: d_im_reg <= (first_reg && kz_reg) ? '0 : mul_res;
                OP_DEN: den_reg  <= sat48(b_reg - mul_res_w);
                OP_RRE: d_re_reg <= sat48({{(WW-VW){d_re_reg[VW-1]}}, d_re_reg} - mul_res_w);
                OP_RIM: d_im_reg <= sat48({{(WW-VW){d_im_reg[VW-1]}}, d_im_reg} - mul_res_w);
                default: ;
            endcase
        end
        if (cmd.den_first)
            den_reg <= sat48(b_reg);
        if (cmd.row_commit)
            mem[row_count_reg] <= {cp_val, dp_re_val, dp_im_val};
        if (mem_re)
            rd_reg <= mem[mem_raddr];
        if (cmd.out_load)
        begin
            press_re_reg <= out32(sol_re_reg);
            press_im_reg <= out32(sol_im_reg);
            singular_reg <= pivot_reg;
            last_out_reg <= (idx_reg == '0);
        end
    end

    always_comb
    begin
        stat.mul_done = mul_done;
        stat.div_done = div_done;
        stat.first    = first_reg;
        stat.last     = last_reg;
        stat.idx_zero = (idx_reg == '0);
        stat.out_free = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign press_re  = press_re_reg;
    assign press_im  = press_im_reg;
    assign singular  = singular_reg;
    assign last_out  = last_out_reg;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten while held");

    a_row_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.row_commit && !last_reg) |=> (row_count_reg == $past(row_count_reg) + 1'b1))
        else $error("row counter did not advance");

endmodule

/* src/poisson_column_tridiagonal_solve.sv */
// Flow: a middle row passes from acceptance through five multiplies on the shared 24x24 unit,
// a divider start, the radix-2 divider and a commit; a first row takes two multiplies.
// A row is taken only after the previous row commits; a column of n rows then emits n results,
// each after the first needing two multiplies, held in an output register.
// Reset: asynchronous, active low; clears control, counters and configuration to 1.0.
// The sweep store is not cleared; every entry is written before its value is used.
module poisson_column_tridiagonal_solve #(
    parameter int LEVELS = pctd_pkg::LEVELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [31:0]         kh_sq,
    input  logic signed [31:0]  div_re,
    input  logic signed [31:0]  div_im,
    input  logic                last_row,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  press_re,
    output logic signed [31:0]  press_im,
    output logic                singular,
    output logic                last_out,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import pctd_pkg::*;

    pctd_cmd_t  cmd;
    pctd_stat_t stat;

    assign cfg_ready = 1'b1;

    pctd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    pctd_datapath #(
        .LEVELS (LEVELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .kh_sq     (kh_sq),
        .div_re    (div_re),
        .div_im    (div_im),
        .last_row  (last_row),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .press_re  (press_re),
        .press_im  (press_im),
        .singular  (singular),
        .last_out  (last_out)
    );

endmodule
